// File: rtl/core/linear_ramp_generator_assert.svh
// Assertion macros for the linear ramp generator checker.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef LINEAR_RAMP_GENERATOR_ASSERT_SVH
`define LINEAR_RAMP_GENERATOR_ASSERT_SVH

// same-cycle implication
`define LRG_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LRG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/lrg_pkg.sv
// Shared constants, datapath command codes and control structs
// for the linear ramp generator. No dependencies.
package lrg_pkg;

    localparam int VALUE_BITS      = 24;
    localparam int COUNT_FRAC_BITS = 16;
    localparam int DUR_BITS        = 24;
    localparam int RATE_BITS       = 18;
    localparam int COUNT_BITS      = 40;
    localparam int DIFF_BITS       = VALUE_BITS + 1;
    localparam int SUM_BITS        = VALUE_BITS + 3;
    localparam int STEP_MAG_BITS   = 47;
    localparam int STEP_FRAC_BITS  = 22;
    localparam int DIV_SHIFT       = COUNT_FRAC_BITS + STEP_FRAC_BITS;
    localparam int DIV_STEPS       = STEP_MAG_BITS;
    localparam int DIV_PRE         = DIV_STEPS - DIV_SHIFT;
    localparam int DIV_CNT_BITS    = $clog2(DIV_STEPS);
    localparam int MUL_B_BITS      = 24;
    localparam int PROD_BITS       = COUNT_BITS + MUL_B_BITS;
    localparam int ACC_BITS        = PROD_BITS + MUL_B_BITS;
    localparam int OFF_BITS        = VALUE_BITS + 1;
    localparam int OFF_TOP         = DIV_SHIFT + OFF_BITS;
    localparam int NEAR_MAG        = ((1 << (VALUE_BITS - 2)) - 1) / 1000000;

    localparam logic [COUNT_BITS-1:0] ONE_SAMPLE  = COUNT_BITS'(1) << COUNT_FRAC_BITS;
    localparam logic [COUNT_BITS:0]   COUNT_LIMIT = {1'b1, {COUNT_BITS{1'b0}}};
    localparam logic [RATE_BITS-1:0]  RATE_RESET  = RATE_BITS'(8000);

    localparam logic [1:0] REQ_TICK = 2'd0;
    localparam logic [1:0] REQ_SET  = 2'd1;
    localparam logic [1:0] REQ_RAMP = 2'd2;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_DECODE,
        OP_RAMP_CHK,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_MUL_LO,
        OP_MUL_HI,
        OP_MUL_ACC,
        OP_TICK_FIN
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   out_load;
    } lrg_cmd_t;

    typedef struct packed {
        logic [1:0] req;
        logic       tick_short;
        logic       ramp_short;
        logic       div_sat;
        logic       div_last;
    } lrg_sts_t;

endpackage

// File: rtl/core/lrg_ctrl.sv
// Request sequencer for the linear ramp generator.
// Uses lrg_pkg; drives lrg_dp through lrg_cmd_t, reads lrg_sts_t.
module lrg_ctrl import lrg_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    output logic     out_valid,
    input  logic     out_stall,
    output lrg_cmd_t cmd,
    input  lrg_sts_t sts
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DEC,
        S_RCHK,
        S_DINIT,
        S_DIV,
        S_MUL0,
        S_MUL1,
        S_MACC,
        S_TFIN,
        S_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd.op         = OP_NONE;
        cmd.out_load   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_CAPTURE;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                cmd.op = OP_DECODE;
                priority if (sts.req == REQ_TICK)
                    state_next = sts.tick_short ? S_EMIT : S_MUL0;
                else if (sts.req == REQ_RAMP)
                    state_next = S_RCHK;
                else
                    state_next = S_EMIT;
            end
            S_RCHK:
            begin
                cmd.op     = OP_RAMP_CHK;
                state_next = sts.ramp_short ? S_EMIT : S_DINIT;
            end
            S_DINIT:
            begin
                cmd.op     = OP_DIV_INIT;
                state_next = sts.div_sat ? S_EMIT : S_DIV;
            end
            S_DIV:
            begin
                cmd.op = OP_DIV_STEP;
                if (sts.div_last)
                    state_next = S_EMIT;
            end
            S_MUL0:
            begin
                cmd.op     = OP_MUL_LO;
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                cmd.op     = OP_MUL_HI;
                state_next = S_MACC;
            end
            S_MACC:
            begin
                cmd.op     = OP_MUL_ACC;
                state_next = S_TFIN;
            end
            S_TFIN:
            begin
                cmd.op     = OP_TICK_FIN;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: rtl/core/lrg_dp.sv
// Datapath of the linear ramp generator: ramp state, count multiplier,
// serial step divider, split tick multiplier, output register. Uses lrg_pkg.
module lrg_dp import lrg_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  lrg_cmd_t                     cmd,
    output lrg_sts_t                     sts,
    input  logic                         cfg_we,
    input  logic [RATE_BITS-1:0]         cfg_data,
    input  logic [1:0]                   req_type,
    input  logic signed [VALUE_BITS-1:0] value,
    input  logic [DUR_BITS-1:0]          ramp_duration,
    output logic signed [VALUE_BITS-1:0] sample,
    output logic                         ramping,
    output logic signed [VALUE_BITS-1:0] target_out
);

    // ramp state
    logic [RATE_BITS-1:0]         rate_reg, rate_next;
    logic signed [VALUE_BITS-1:0] cur_reg, cur_next;
    logic signed [VALUE_BITS-1:0] tgt_reg, tgt_next;
    logic [COUNT_BITS-1:0]        left_reg, left_next;
    logic                         step_neg_reg, step_neg_next;
    logic [STEP_MAG_BITS-1:0]     step_mag_reg, step_mag_next;

    // working registers
    logic [1:0]                   req_reg, req_next;
    logic signed [VALUE_BITS-1:0] val_reg, val_next;
    logic [DUR_BITS-1:0]          dur_reg, dur_next;
    logic signed [VALUE_BITS-1:0] shown_reg, shown_next;
    logic [COUNT_BITS:0]          count_reg, count_next;
    logic                         diff_neg_reg, diff_neg_next;
    logic [DIFF_BITS-1:0]         diff_mag_reg, diff_mag_next;
    logic [COUNT_BITS-1:0]        rem_reg, rem_next;
    logic [STEP_MAG_BITS-1:0]     quot_reg, quot_next;
    logic [DIV_PRE-1:0]           src_reg, src_next;
    logic [DIV_CNT_BITS-1:0]      div_cnt_reg, div_cnt_next;
    logic [PROD_BITS-1:0]         prod_reg, prod_next;
    logic [ACC_BITS-1:0]          acc_reg, acc_next;
    logic signed [VALUE_BITS-1:0] sample_reg, sample_next;
    logic                         ramping_reg, ramping_next;
    logic signed [VALUE_BITS-1:0] target_reg, target_next;

    logic signed [DIFF_BITS-1:0]        diff;
    logic [DUR_BITS+RATE_BITS-1:0]      raw_count;
    logic [COUNT_BITS:0]                count_dec;
    logic [MUL_B_BITS-1:0]              mul_b;
    logic [PROD_BITS-1:0]               mul_p;
    logic [COUNT_BITS:0]                r2;
    logic [COUNT_BITS:0]                r2_sub;
    logic                               r2_fits;
    logic [STEP_MAG_BITS-1:0]           quot_step;
    logic [OFF_BITS-1:0]                off;
    logic signed [SUM_BITS-1:0]         tsum;
    logic signed [VALUE_BITS-1:0]       tval;

    assign diff      = {val_reg[VALUE_BITS-1], val_reg} - {cur_reg[VALUE_BITS-1], cur_reg};
    assign raw_count = (DUR_BITS+RATE_BITS)'(dur_reg) * (DUR_BITS+RATE_BITS)'(rate_reg);
    assign count_dec = count_reg - {1'b0, ONE_SAMPLE};

    assign mul_b = (cmd.op == OP_MUL_HI)
                 ? MUL_B_BITS'(step_mag_reg[STEP_MAG_BITS-1:MUL_B_BITS])
                 : step_mag_reg[MUL_B_BITS-1:0];
    assign mul_p = PROD_BITS'(left_reg) * PROD_BITS'(mul_b);

    assign r2        = {rem_reg, src_reg[DIV_PRE-1]};
    assign r2_fits   = (r2 >= {1'b0, left_reg});
    assign r2_sub    = r2 - {1'b0, left_reg};
    assign quot_step = {quot_reg[STEP_MAG_BITS-2:0], r2_fits};

    assign off  = (|acc_reg[ACC_BITS-1:OFF_TOP]) ? {OFF_BITS{1'b1}}
                                                 : acc_reg[OFF_TOP-1:DIV_SHIFT];
    assign tsum = step_neg_reg
                ? ({{3{tgt_reg[VALUE_BITS-1]}}, tgt_reg} + $signed({2'b00, off}))
                : ({{3{tgt_reg[VALUE_BITS-1]}}, tgt_reg} - $signed({2'b00, off}));

    always_comb
    begin
        if (tsum[SUM_BITS-1:VALUE_BITS-1] == {(SUM_BITS-VALUE_BITS+1){1'b0}} ||
            tsum[SUM_BITS-1:VALUE_BITS-1] == {(SUM_BITS-VALUE_BITS+1){1'b1}})
            tval = tsum[VALUE_BITS-1:0];
        else if (tsum[SUM_BITS-1])
            tval = {1'b1, {(VALUE_BITS-1){1'b0}}};
        else
            tval = {1'b0, {(VALUE_BITS-1){1'b1}}};
    end

    assign sts.req        = req_reg;
    assign sts.tick_short = ~|left_reg[COUNT_BITS-1:COUNT_FRAC_BITS];
    assign sts.ramp_short = (count_reg <= {1'b0, ONE_SAMPLE}) ||
                            (diff_mag_reg <= DIFF_BITS'(NEAR_MAG));
    assign sts.div_sat    = ((COUNT_BITS+DIV_PRE)'(diff_mag_reg) >=
                             {left_reg, {DIV_PRE{1'b0}}});
    assign sts.div_last   = (div_cnt_reg == DIV_CNT_BITS'(DIV_STEPS - 1));

    always_comb
    begin
        rate_next     = cfg_we ? cfg_data : rate_reg;
        cur_next      = cur_reg;
        tgt_next      = tgt_reg;
        left_next     = left_reg;
        step_neg_next = step_neg_reg;
        step_mag_next = step_mag_reg;
        req_next      = req_reg;
        val_next      = val_reg;
        dur_next      = dur_reg;
        shown_next    = shown_reg;
        count_next    = count_reg;
        diff_neg_next = diff_neg_reg;
        diff_mag_next = diff_mag_reg;
        rem_next      = rem_reg;
        quot_next     = quot_reg;
        src_next      = src_reg;
        div_cnt_next  = div_cnt_reg;
        prod_next     = prod_reg;
        acc_next      = acc_reg;
        sample_next   = sample_reg;
        ramping_next  = ramping_reg;
        target_next   = target_reg;

        unique case (cmd.op)
            OP_NONE:
            begin
            end
            OP_CAPTURE:
            begin
                req_next   = req_type;
                val_next   = value;
                dur_next   = ramp_duration;
                shown_next = cur_reg;
            end
            OP_DECODE:
            begin
                priority if (req_reg == REQ_TICK)
                begin
                    if (sts.tick_short)
                        cur_next = tgt_reg;
                    else
                        left_next = left_reg - ONE_SAMPLE;
                end
                else if (req_reg == REQ_SET)
                begin
                    cur_next  = val_reg;
                    tgt_next  = val_reg;
                    left_next = '0;
                end
                else if (req_reg == REQ_RAMP)
                begin
                    tgt_next      = val_reg;
                    count_next    = (raw_count > (DUR_BITS+RATE_BITS)'(COUNT_LIMIT))
                                  ? COUNT_LIMIT : raw_count[COUNT_BITS:0];
                    diff_neg_next = diff[DIFF_BITS-1];
                    diff_mag_next = diff[DIFF_BITS-1] ? DIFF_BITS'(-diff) : DIFF_BITS'(diff);
                end
                else
                begin
                end
            end
            OP_RAMP_CHK:
            begin
                if (sts.ramp_short)
                begin
                    cur_next  = tgt_reg;
                    left_next = '0;
                end
                else
                    left_next = count_dec[COUNT_BITS-1:0];
            end
            OP_DIV_INIT:
            begin
                rem_next     = COUNT_BITS'(diff_mag_reg[DIFF_BITS-1:DIV_PRE]);
                src_next     = diff_mag_reg[DIV_PRE-1:0];
                quot_next    = '0;
                div_cnt_next = '0;
                if (sts.div_sat)
                begin
                    step_neg_next = diff_neg_reg;
                    step_mag_next = {STEP_MAG_BITS{1'b1}};
                end
            end
            OP_DIV_STEP:
            begin
                rem_next     = r2_fits ? r2_sub[COUNT_BITS-1:0] : r2[COUNT_BITS-1:0];
                quot_next    = quot_step;
                src_next     = {src_reg[DIV_PRE-2:0], 1'b0};
                div_cnt_next = div_cnt_reg + 1'b1;
                if (sts.div_last)
                begin
                    step_neg_next = diff_neg_reg;
                    step_mag_next = quot_step;
                end
            end
            OP_MUL_LO:
            begin
                prod_next = mul_p;
            end
            OP_MUL_HI:
            begin
                acc_next  = ACC_BITS'(prod_reg);
                prod_next = mul_p;
            end
            OP_MUL_ACC:
            begin
                acc_next = acc_reg + {prod_reg, {MUL_B_BITS{1'b0}}};
            end
            OP_TICK_FIN:
            begin
                cur_next = tval;
            end
            default:
            begin
            end
        endcase

        if (cmd.out_load)
        begin
            sample_next  = (req_reg == REQ_TICK) ? shown_reg : cur_reg;
            ramping_next = |left_reg[COUNT_BITS-1:COUNT_FRAC_BITS];
            target_next  = tgt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg     <= RATE_RESET;
            cur_reg      <= '0;
            tgt_reg      <= '0;
            left_reg     <= '0;
            step_neg_reg <= 1'b0;
            step_mag_reg <= '0;
        end
        else
        begin
            rate_reg     <= rate_next;
            cur_reg      <= cur_next;
            tgt_reg      <= tgt_next;
            left_reg     <= left_next;
            step_neg_reg <= step_neg_next;
            step_mag_reg <= step_mag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        val_reg      <= val_next;
        dur_reg      <= dur_next;
        shown_reg    <= shown_next;
        count_reg    <= count_next;
        diff_neg_reg <= diff_neg_next;
        diff_mag_reg <= diff_mag_next;
        rem_reg      <= rem_next;
        quot_reg     <= quot_next;
        src_reg      <= src_next;
        div_cnt_reg  <= div_cnt_next;
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        sample_reg   <= sample_next;
        ramping_reg  <= ramping_next;
        target_reg   <= target_next;
    end

    assign sample     = sample_reg;
    assign ramping    = ramping_reg;
    assign target_out = target_reg;

endmodule

// File: rtl/core/linear_ramp_generator.sv
// Linear ramp generator for a Q2.22 control value.
// Input channel (in_valid/in_stall) carries one request: req_type 0 tick,
// 1 set value, 2 ramp to value over ramp_duration (Q8.16 seconds).
// Output channel (out_valid/out_stall) returns one result per request:
// sample, ramping flag and current target.
// cfg_we/cfg_data writes the output rate (samples per second), reset value
// 8000; write only while no request is in flight.
// Steps after accept: tick at the end of a ramp or idle, set and unused code
// go from decode to the output; tick while ramping uses the 40x24 multiplier
// twice, then accumulates and clamps; a ramp request ends after the ramp
// check if it finishes at once, after divider init if the step saturates,
// otherwise after the one-bit-per-cycle step divider (47 quotient bits).
// One request is worked on at a time; the next is accepted the cycle after
// the result enters the output register.
// A result held by out_stall stays in the output register; a new request
// may be taken meanwhile but its result waits until the register frees.
// Reset clears value, target, remaining count and step, and loads the rate.
// Depends on lrg_pkg, lrg_ctrl, lrg_dp.
module linear_ramp_generator import lrg_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [RATE_BITS-1:0]         cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   req_type,
    input  logic signed [VALUE_BITS-1:0] value,
    input  logic [DUR_BITS-1:0]          ramp_duration,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [VALUE_BITS-1:0] sample,
    output logic                         ramping,
    output logic signed [VALUE_BITS-1:0] target_out
);

    lrg_cmd_t cmd;
    lrg_sts_t sts;

    lrg_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    lrg_dp u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .req_type      (req_type),
        .value         (value),
        .ramp_duration (ramp_duration),
        .sample        (sample),
        .ramping       (ramping),
        .target_out    (target_out)
    );

endmodule

// File: rtl/core/lrg_checker.sv
// Port-level checks for linear_ramp_generator, bound to the top level.
// Uses lrg_pkg and the macros in linear_ramp_generator_assert.svh.
`include "linear_ramp_generator_assert.svh"
module lrg_checker import lrg_pkg::*;
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic signed [VALUE_BITS-1:0] sample,
    input logic                         ramping,
    input logic signed [VALUE_BITS-1:0] target_out
);

    `LRG_ASSERT_NEXT(a_out_held, out_valid && out_stall, out_valid, "result dropped while stalled")
    `LRG_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(sample) && $stable(ramping) && $stable(target_out), "stalled result changed")
    `LRG_ASSERT_NEXT(a_busy_after_req, in_valid && !in_stall, in_stall, "second request taken while busy")
    `LRG_ASSERT_SAME(a_result_from_work, $rose(out_valid), $past(in_stall), "result without request in progress")

endmodule

bind linear_ramp_generator lrg_checker u_lrg_checker (.*);
